// File: rtl/pgs_pkg.sv
// Shared constants and types for the polar Gaussian sampler.
// No dependencies; used by the cells and by the top level.
`default_nettype none

package pgs_pkg;

  // Mantissa of the log unit is Q1.30, held in 31 bits.
  localparam int unsigned M_FRAC    = 30;
  localparam int unsigned MANT_W    = 31;
  // Fraction bits of the base-two logarithm.
  localparam int unsigned LOG_FRAC  = 24;
  // Quotient bits of x1^2 / w in Q1.32 (the value can reach 1.0).
  localparam int unsigned DIV_STEPS = 33;
  // Width of the standard deviation and mean registers.
  localparam int unsigned STD_W     = 31;
  localparam int unsigned MEAN_W    = 32;

  // 2 ln 2 in Q.30, rounded to nearest.
  localparam logic [MANT_W-1:0] TWO_LN2_Q30 = 31'h58B90BFC;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 2;
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MEAN = 2'd0,
    CFG_STD  = 2'd1
  } cfg_reg_e;

endpackage

`default_nettype wire

// File: rtl/pgs_div_log_cell.sv
// One cell of the divider and logarithm chain: a restoring division step
// on x1^2 / w and, when enabled, one squaring step of the log2 fraction.
// Depends on pgs_pkg.
`default_nettype none

module pgs_div_log_cell
  import pgs_pkg::*;
#(
  parameter int unsigned WW     = 30,
  parameter int unsigned EW     = 5,
  parameter bit          DO_LOG = 1'b1
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 en_i,
  input  wire logic                 valid_i,
  input  wire logic                 neg_i,
  input  wire logic [EW-1:0]        e_i,
  input  wire logic [WW:0]          rem_i,
  input  wire logic [WW-1:0]        w_i,
  input  wire logic [DIV_STEPS-1:0] r_i,
  input  wire logic [MANT_W-1:0]    m_i,
  input  wire logic [LOG_FRAC-1:0]  f_i,
  output logic                      valid_o,
  output logic                      neg_o,
  output logic [EW-1:0]             e_o,
  output logic [WW:0]               rem_o,
  output logic [WW-1:0]             w_o,
  output logic [DIV_STEPS-1:0]      r_o,
  output logic [MANT_W-1:0]         m_o,
  output logic [LOG_FRAC-1:0]       f_o
);

  logic                 take;
  logic [WW:0]          diff;
  logic [WW:0]          rem_sel;
  logic [WW:0]          rem_d;
  logic [DIV_STEPS-1:0] r_d;
  logic [MANT_W-1:0]    m_d;
  logic [LOG_FRAC-1:0]  f_d;

  // Division step: subtract the divisor when it fits and shift the remainder.
  always_comb begin
    take    = (rem_i >= {1'b0, w_i});
    diff    = rem_i - {1'b0, w_i};
    rem_sel = take ? diff : rem_i;
    rem_d   = {rem_sel[WW-1:0], 1'b0};
    r_d     = {r_i[DIV_STEPS-2:0], take};
  end

  // Logarithm step: square the mantissa and renormalize on overflow.
  if (DO_LOG) begin : g_log
    logic [2*MANT_W-1:0] sq;
    logic [MANT_W:0]     sq_sh;
    always_comb begin
      sq    = {{MANT_W{1'b0}}, m_i} * {{MANT_W{1'b0}}, m_i};
      sq_sh = sq[M_FRAC +: MANT_W+1];
      if (sq_sh[MANT_W]) begin
        m_d = sq_sh[MANT_W:1];
        f_d = {f_i[LOG_FRAC-2:0], 1'b1};
      end else begin
        m_d = sq_sh[MANT_W-1:0];
        f_d = {f_i[LOG_FRAC-2:0], 1'b0};
      end
    end
  end else begin : g_pass
    always_comb begin
      m_d = m_i;
      f_d = f_i;
    end
  end

  // Valid bit of the cell.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= valid_i;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      neg_o <= neg_i;
      e_o   <= e_i;
      rem_o <= rem_d;
      w_o   <= w_i;
      r_o   <= r_d;
      m_o   <= m_d;
      f_o   <= f_d;
    end
  end

endmodule

`default_nettype wire

// File: rtl/pgs_sqrt_cell.sv
// One cell of the integer square root chain: settles one result bit.
// Depends on pgs_pkg.
`default_nettype none

module pgs_sqrt_cell
  import pgs_pkg::*;
#(
  parameter int unsigned XW = 41,
  parameter int unsigned K  = 0
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          en_i,
  input  wire logic          valid_i,
  input  wire logic          neg_i,
  input  wire logic [XW-1:0] x_i,
  input  wire logic [XW-1:0] res_i,
  output logic               valid_o,
  output logic               neg_o,
  output logic [XW-1:0]      x_o,
  output logic [XW-1:0]      res_o
);

  localparam logic [XW-1:0] BIT = {{(XW-1){1'b0}}, 1'b1} << (2*K);

  logic [XW-1:0] trial;
  logic [XW-1:0] x_d;
  logic [XW-1:0] res_d;

  // Try to subtract res + bit; the result bit is set when it fits.
  always_comb begin
    trial = res_i + BIT;
    if (x_i >= trial) begin
      x_d   = x_i - trial;
      res_d = (res_i >> 1) + BIT;
    end else begin
      x_d   = x_i;
      res_d = res_i >> 1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      neg_o <= neg_i;
      x_o   <= x_d;
      res_o <= res_d;
    end
  end

endmodule

`default_nettype wire

// File: rtl/polar_gaussian_sample.sv
// Polar-method Gaussian sampler: one candidate pair per beat, rejected pairs vanish.
// Throughput is one pair per cycle unless the output stalls, set by the fully pipelined
// divider/log chain and sqrt chain.
// The whole pipeline stalls together while a result waits at the output register.
// Reset (async, active low) clears all valid bits, mean to 0 and std_dev to 1.0.
// Depends on pgs_pkg, pgs_div_log_cell and pgs_sqrt_cell.
`default_nettype none

module polar_gaussian_sample
  import pgs_pkg::*;
#(
  parameter int unsigned UNIFORM_BITS = 16
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    cfg_valid_i,
  output logic                         cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]    cfg_index_i,
  input  wire logic [MEAN_W-1:0]       cfg_data_i,
  input  wire logic                    in_valid_i,
  output logic                         in_ready_o,
  input  wire logic [UNIFORM_BITS-1:0] first_uniform_i,
  input  wire logic [UNIFORM_BITS-1:0] second_uniform_i,
  output logic                         out_valid_o,
  input  wire logic                    out_ready_i,
  output logic signed [MEAN_W-1:0]     sample_o
);

  localparam int unsigned B    = UNIFORM_BITS;
  localparam int unsigned WW   = 2*B - 2;
  localparam int unsigned EW   = $clog2(WW);
  localparam int unsigned NW   = $clog2(WW+1) + LOG_FRAC;
  localparam int unsigned LW   = NW + 1;
  localparam int unsigned PW   = NW + MANT_W;
  localparam int unsigned RLO  = 16;
  localparam int unsigned RHI  = DIV_STEPS - RLO;
  localparam int unsigned SUMW = DIV_STEPS + LW;
  localparam int unsigned QW   = SUMW - LOG_FRAC;
  localparam int unsigned SQW  = (QW + 1) / 2;
  localparam int unsigned XW   = 2*SQW + 1;
  localparam int unsigned MW   = SQW + STD_W - 16;
  localparam int unsigned SW   = MW + 2;

  logic adv;

  // Configuration registers; writes are always taken.
  logic signed [MEAN_W-1:0] mean_q;
  logic [STD_W-1:0]         std_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mean_q <= '0;
      std_q  <= STD_W'(32'd65536);
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        CFG_MEAN: mean_q <= cfg_data_i;
        CFG_STD:  std_q  <= cfg_data_i[STD_W-1:0];
        default: ;
      endcase
    end
  end

  // The pipeline moves whenever the output register is free or being drained.
  assign adv        = !out_valid_o || out_ready_i;
  assign in_ready_o = adv;

  // Front stage: magnitudes, squared radius and rejection test.
  logic [B-1:0]   a1, a2;
  logic           neg1;
  logic [2*B-1:0] n1_full, n2_full, w_full;
  logic           reject;

  always_comb begin
    neg1    = !first_uniform_i[B-1];
    a1      = neg1 ? ({1'b1, {(B-1){1'b0}}} - first_uniform_i)
                   : {1'b0, first_uniform_i[B-2:0]};
    a2      = !second_uniform_i[B-1] ? ({1'b1, {(B-1){1'b0}}} - second_uniform_i)
                                     : {1'b0, second_uniform_i[B-2:0]};
    n1_full = {{B{1'b0}}, a1} * {{B{1'b0}}, a1};
    n2_full = {{B{1'b0}}, a2} * {{B{1'b0}}, a2};
    w_full  = n1_full + n2_full;
    reject  = (w_full == '0) || (w_full[2*B-1:2*B-2] != 2'b00);
  end

  logic          va_q, nega_q;
  logic [WW-1:0] n1a_q, wa_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
    end else if (adv) begin
      va_q <= in_valid_i && !reject;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      nega_q <= neg1;
      n1a_q  <= n1_full[WW-1:0];
      wa_q   <= w_full[WW-1:0];
    end
  end

  // Normalize stage: leading one of w and the Q1.30 mantissa.
  logic [EW-1:0]     e_c;
  logic [WW-1:0]     norm;
  logic [MANT_W-1:0] m_c;

  always_comb begin
    e_c = '0;
    for (int i = 0; i < WW; i++) begin
      if (wa_q[i]) begin
        e_c = EW'(i);
      end
    end
    norm = wa_q << (EW'(WW-1) - e_c);
  end

  if (WW >= MANT_W) begin : g_mant_cut
    assign m_c = norm[WW-1 -: MANT_W];
  end else begin : g_mant_pad
    assign m_c = {norm, {(MANT_W-WW){1'b0}}};
  end

  logic              vb_q, negb_q;
  logic [EW-1:0]     eb_q;
  logic [WW-1:0]     n1b_q, wb_q;
  logic [MANT_W-1:0] mb_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vb_q <= 1'b0;
    end else if (adv) begin
      vb_q <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      negb_q <= nega_q;
      eb_q   <= e_c;
      n1b_q  <= n1a_q;
      wb_q   <= wa_q;
      mb_q   <= m_c;
    end
  end

  // Divider and logarithm chain.
  logic                 dv    [0:DIV_STEPS];
  logic                 dneg  [0:DIV_STEPS];
  logic [EW-1:0]        de    [0:DIV_STEPS];
  logic [WW:0]          drem  [0:DIV_STEPS];
  logic [WW-1:0]        dw    [0:DIV_STEPS];
  logic [DIV_STEPS-1:0] dr    [0:DIV_STEPS];
  logic [MANT_W-1:0]    dm    [0:DIV_STEPS];
  logic [LOG_FRAC-1:0]  df    [0:DIV_STEPS];

  assign dv[0]   = vb_q;
  assign dneg[0] = negb_q;
  assign de[0]   = eb_q;
  assign drem[0] = {1'b0, n1b_q};
  assign dw[0]   = wb_q;
  assign dr[0]   = '0;
  assign dm[0]   = mb_q;
  assign df[0]   = '0;

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
    pgs_div_log_cell #(
      .WW     (WW),
      .EW     (EW),
      .DO_LOG (k < LOG_FRAC)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (adv),
      .valid_i (dv[k]),
      .neg_i   (dneg[k]),
      .e_i     (de[k]),
      .rem_i   (drem[k]),
      .w_i     (dw[k]),
      .r_i     (dr[k]),
      .m_i     (dm[k]),
      .f_i     (df[k]),
      .valid_o (dv[k+1]),
      .neg_o   (dneg[k+1]),
      .e_o     (de[k+1]),
      .rem_o   (drem[k+1]),
      .w_o     (dw[k+1]),
      .r_o     (dr[k+1]),
      .m_o     (dm[k+1]),
      .f_o     (df[k+1])
    );
  end

  // Stage C: -log2(w) and the scaling to -2 ln w.
  logic [NW-1:0] n_val;
  logic [PW-1:0] l_prod;

  always_comb begin
    n_val  = ((NW'(WW) - NW'(de[DIV_STEPS])) << LOG_FRAC) - NW'(df[DIV_STEPS]);
    l_prod = PW'(n_val) * PW'(TWO_LN2_Q30) + PW'(1 << (M_FRAC-1));
  end

  logic                 vc_q, negc_q;
  logic [DIV_STEPS-1:0] rc_q;
  logic [LW-1:0]        lc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vc_q <= 1'b0;
    end else if (adv) begin
      vc_q <= dv[DIV_STEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      negc_q <= dneg[DIV_STEPS];
      rc_q   <= dr[DIV_STEPS];
      lc_q   <= l_prod[M_FRAC +: LW];
    end
  end

  // Stage D: low partial product of r * L.
  logic              vd_q, negd_q;
  logic [RHI-1:0]    rhid_q;
  logic [LW-1:0]     ld_q;
  logic [RLO+LW-1:0] plod_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vd_q <= 1'b0;
    end else if (adv) begin
      vd_q <= vc_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      negd_q <= negc_q;
      rhid_q <= rc_q[DIV_STEPS-1:RLO];
      ld_q   <= lc_q;
      plod_q <= (RLO+LW)'(rc_q[RLO-1:0]) * (RLO+LW)'(lc_q);
    end
  end

  // Stage E: high partial product and z^2 in Q.32.
  logic [SUMW-1:0] phi;
  logic [SUMW-1:0] psum;

  always_comb begin
    phi  = SUMW'(rhid_q) * SUMW'(ld_q);
    psum = (phi << RLO) + SUMW'(plod_q);
  end

  logic          ve_q, nege_q;
  logic [QW-1:0] qe_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ve_q <= 1'b0;
    end else if (adv) begin
      ve_q <= vd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      nege_q <= negd_q;
      qe_q   <= psum[LOG_FRAC +: QW];
    end
  end

  // Square root chain, most significant result bit first.
  logic          sv   [0:SQW];
  logic          sneg [0:SQW];
  logic [XW-1:0] sx   [0:SQW];
  logic [XW-1:0] sres [0:SQW];

  assign sv[0]   = ve_q;
  assign sneg[0] = nege_q;
  assign sx[0]   = XW'(qe_q);
  assign sres[0] = '0;

  for (genvar j = 0; j < SQW; j++) begin : g_sqrt
    pgs_sqrt_cell #(
      .XW (XW),
      .K  (SQW-1-j)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (adv),
      .valid_i (sv[j]),
      .neg_i   (sneg[j]),
      .x_i     (sx[j]),
      .res_i   (sres[j]),
      .valid_o (sv[j+1]),
      .neg_o   (sneg[j+1]),
      .x_o     (sx[j+1]),
      .res_o   (sres[j+1])
    );
  end

  // Stage F: scale |z| by the standard deviation.
  logic [SQW+STD_W-1:0] mag_prod;
  logic                 vf_q, negf_q;
  logic [MW-1:0]        magf_q;

  assign mag_prod = (SQW+STD_W)'(sres[SQW][SQW-1:0]) * (SQW+STD_W)'(std_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vf_q <= 1'b0;
    end else if (adv) begin
      vf_q <= sv[SQW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      negf_q <= sneg[SQW];
      magf_q <= mag_prod[16 +: MW];
    end
  end

  // Stage G: add the mean and saturate into the output register.
  logic signed [SW-1:0]     sum;
  logic signed [MEAN_W-1:0] sat;

  always_comb begin
    if (negf_q) begin
      sum = SW'(mean_q) - $signed({2'b00, magf_q});
    end else begin
      sum = SW'(mean_q) + $signed({2'b00, magf_q});
    end
    if (sum[SW-1:MEAN_W-1] == '0 || sum[SW-1:MEAN_W-1] == '1) begin
      sat = sum[MEAN_W-1:0];
    end else if (sum[SW-1]) begin
      sat = {1'b1, {(MEAN_W-1){1'b0}}};
    end else begin
      sat = {1'b0, {(MEAN_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (adv) begin
      out_valid_o <= vf_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sample_o <= sat;
    end
  end

endmodule

`default_nettype wire
